// ===== hw/rtl/lzwd_pkg.sv =====
// ---------------------------------------------------------------------------
// LZW code decoder package
// Shared constants and types for the LZW code decoder.
// ---------------------------------------------------------------------------
package lzwd_pkg;

    localparam int LITERALS = 256;
    localparam int BYTE_W   = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_FETCH,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic start;
        logic err;
    } t_emit_cmd;

endpackage

// ===== hw/rtl/lzwd_emit.sv =====
// ---------------------------------------------------------------------------
// LZW decoder string output stage
// Holds the decoded string in a byte buffer and plays it out, first byte
// first, through a registered read stage and an output register.
// ---------------------------------------------------------------------------
module lzwd_emit
    import lzwd_pkg::*;
#(
    parameter int MAX_STRING = 64,
    parameter int LEN_W      = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_emit_cmd                     i_cmd,
    input  logic [LEN_W-1:0]              i_len,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_STRING)-1:0] i_wr_addr,
    input  logic [BYTE_W-1:0]             i_wr_byte,
    output logic                          o_busy,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [BYTE_W-1:0]             o_data_byte,
    output logic                          o_last,
    output logic                          o_error
);

    localparam int IDX_W = $clog2(MAX_STRING);

    logic [BYTE_W-1:0] r_buf [MAX_STRING];
    logic [BYTE_W-1:0] r_brd;
    logic              r_busy;
    logic              r_err;
    logic [LEN_W-1:0]  r_len;
    logic [IDX_W-1:0]  r_k;
    logic              r_rv;
    logic              r_rerr;
    logic              r_rlast;
    logic              r_ov;
    logic [BYTE_W-1:0] r_ob;
    logic              r_olast;
    logic              r_oerr;

    logic load_out;
    logic issue;
    logic is_last;

    assign load_out = r_rv && (!r_ov || !i_out_stall);
    assign issue    = r_busy && (!r_rv || load_out);
    assign is_last  = r_err || ((LEN_W'(r_k) + LEN_W'(1)) == r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rv   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (issue) begin
                r_rv <= 1'b1;
                if (is_last) begin
                    r_busy <= 1'b0;
                end
            end else if (load_out) begin
                r_rv <= 1'b0;
            end
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_err <= i_cmd.err;
            r_len <= i_len;
            r_k   <= '0;
        end else if (issue) begin
            r_k <= r_k + IDX_W'(1);
        end
        if (issue) begin
            r_rerr  <= r_err;
            r_rlast <= is_last;
        end
        if (load_out) begin
            r_ob    <= r_rerr ? '0 : r_brd;
            r_olast <= r_rlast;
            r_oerr  <= r_rerr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_buf[i_wr_addr] <= i_wr_byte;
        end
        if (issue) begin
            r_brd <= r_buf[r_k];
        end
    end

    assign o_busy      = r_busy;
    assign o_out_valid = r_ov;
    assign o_data_byte = r_ob;
    assign o_last      = r_olast;
    assign o_error     = r_oerr;

endmodule

// ===== hw/rtl/lzw_code_decoder_core.sv =====
// ---------------------------------------------------------------------------
// LZW code decoder core
// Expands one LZW code per transaction into its string of bytes, growing
// the dictionary as it goes and flagging undefined or over-long strings.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake                 | Payload
//  input   | in        | i_in_valid / o_in_stall   | i_code
//  output  | out       | o_out_valid / i_out_stall | o_data_byte, o_last, o_error
//
//  A code is accepted, looked up, refetched after the dictionary update and
//  walked down its prefix chain into the string buffer; playout then gives
//  one byte per cycle while the output is not stalled. The next code is
//  accepted during playout, but its lookup waits until the output stage has
//  read the last byte from its buffer. Reset clears the control state only.
//  A stalled output holds the playout and so the next code.
// ---------------------------------------------------------------------------
module lzw_code_decoder_core
    import lzwd_pkg::*;
#(
    parameter int CODE_BITS  = 12,
    parameter int MAX_STRING = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CODE_BITS-1:0] i_code,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_W-1:0]    o_data_byte,
    output logic                 o_last,
    output logic                 o_error
);

    localparam int LEN_W = $clog2(MAX_STRING + 2);
    localparam int IDX_W = $clog2(MAX_STRING);
    localparam int ENT_W = CODE_BITS + 2 * BYTE_W + LEN_W;
    localparam int DICT  = 1 << CODE_BITS;

    t_state r_state;
    t_state n_state;

    logic [ENT_W-1:0]     r_dict [DICT];
    logic [ENT_W-1:0]     r_rd;
    logic [CODE_BITS:0]   r_nfc;
    logic [CODE_BITS-1:0] r_prev;
    logic                 r_have;
    logic [LEN_W-1:0]     r_prev_len;
    logic [BYTE_W-1:0]    r_prev_first;
    logic [CODE_BITS-1:0] r_code;
    logic [CODE_BITS-1:0] r_cur;
    logic [IDX_W-1:0]     r_idx;
    logic [LEN_W-1:0]     r_len;

    logic [CODE_BITS-1:0] rd_prefix;
    logic [BYTE_W-1:0]    rd_suffix;
    logic [BYTE_W-1:0]    rd_first;
    logic [LEN_W-1:0]     rd_len;

    logic [LEN_W-1:0]     sel_len;
    logic [BYTE_W-1:0]    sel_first;
    logic                 bad;
    logic                 add_ok;
    logic                 walk_step;
    logic                 emit_busy;

    logic                 dict_we;
    logic [CODE_BITS-1:0] dict_wa;
    logic [ENT_W-1:0]     dict_wd;
    logic [CODE_BITS-1:0] dict_ra;
    t_emit_cmd            emit_cmd;
    logic                 buf_we;
    logic [BYTE_W-1:0]    buf_byte;

    assign rd_prefix = r_rd[ENT_W-1 -: CODE_BITS];
    assign rd_suffix = r_rd[LEN_W+2*BYTE_W-1 -: BYTE_W];
    assign rd_first  = r_rd[LEN_W+BYTE_W-1 -: BYTE_W];
    assign rd_len    = r_rd[LEN_W-1:0];

    always_comb begin
        sel_len   = '0;
        sel_first = '0;
        if (r_code < CODE_BITS'(LITERALS)) begin
            sel_len   = LEN_W'(1);
            sel_first = r_code[BYTE_W-1:0];
        end else if ({1'b0, r_code} < r_nfc) begin
            sel_len   = rd_len;
            sel_first = rd_first;
        end else if (({1'b0, r_code} == r_nfc) && r_have) begin
            sel_len   = r_prev_len + LEN_W'(1);
            sel_first = r_prev_first;
        end
    end

    assign bad       = (sel_len == '0) || (sel_len > LEN_W'(MAX_STRING));
    assign add_ok    = r_have && !r_nfc[CODE_BITS];
    assign walk_step = (r_cur >= CODE_BITS'(LITERALS)) && (r_idx != '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!emit_busy) begin
                    n_state = bad ? ST_IDLE : ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (!walk_step) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        dict_we        = 1'b0;
        dict_wa        = r_nfc[CODE_BITS-1:0];
        dict_wd        = {r_prev, sel_first, r_prev_first, r_prev_len + LEN_W'(1)};
        dict_ra        = r_code;
        emit_cmd.start = 1'b0;
        emit_cmd.err   = 1'b0;
        buf_we         = 1'b0;
        buf_byte       = walk_step ? rd_suffix : r_cur[BYTE_W-1:0];
        case (r_state)
            ST_IDLE: begin
                dict_ra = i_code;
            end
            ST_LOOK: begin
                if (!emit_busy) begin
                    dict_we        = !bad && add_ok;
                    emit_cmd.start = bad;
                    emit_cmd.err   = bad;
                end
            end
            ST_FETCH: begin
                dict_ra = r_code;
            end
            ST_WALK: begin
                dict_ra        = rd_prefix;
                buf_we         = 1'b1;
                emit_cmd.start = !walk_step;
            end
            default: begin
                dict_ra = r_code;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_nfc   <= (CODE_BITS + 1)'(LITERALS);
            r_prev  <= '0;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_LOOK) && !emit_busy && !bad) begin
                r_prev <= r_code;
                r_have <= 1'b1;
                if (add_ok) begin
                    r_nfc <= r_nfc + (CODE_BITS + 1)'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_in_valid) begin
            r_code <= i_code;
        end
        if ((r_state == ST_LOOK) && !emit_busy && !bad) begin
            r_prev_len   <= sel_len;
            r_prev_first <= sel_first;
            r_len        <= sel_len;
            r_cur        <= r_code;
            r_idx        <= IDX_W'(sel_len - LEN_W'(1));
        end else if ((r_state == ST_WALK) && walk_step) begin
            r_cur <= rd_prefix;
            r_idx <= r_idx - IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (dict_we) begin
            r_dict[dict_wa] <= dict_wd;
        end
        r_rd <= r_dict[dict_ra];
    end

    lzwd_emit #(
        .MAX_STRING (MAX_STRING),
        .LEN_W      (LEN_W)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (emit_cmd),
        .i_len       (r_len),
        .i_wr_en     (buf_we),
        .i_wr_addr   (r_idx),
        .i_wr_byte   (buf_byte),
        .o_busy      (emit_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_byte (o_data_byte),
        .o_last      (o_last),
        .o_error     (o_error)
    );

endmodule
